[design/partial_min_heap_sort_macros.svh]
// Assertion macros for the partial min-heap sort checker.
// No dependencies.
`ifndef PARTIAL_MIN_HEAP_SORT_MACROS_SVH
`define PARTIAL_MIN_HEAP_SORT_MACROS_SVH

// clocked assertion, off while reset is active
`define PMHS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion checked also during reset
`define PMHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/pmhs_pkg.sv]
// Package for the partial min-heap sort: payload structs, state enum, constants.
// No dependencies.
package pmhs_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int VAL_W         = 32;
    localparam int EXT_W         = 7;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last_in;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] value_out;
        logic                    has_value;
        logic                    last_out;
    } t_out;

    typedef enum logic [3:0] {
        S_LOAD,
        S_RD_MOV,
        S_GOT_MOV,
        S_CHK,
        S_C1,
        S_DEC,
        S_WR,
        S_X_RD0,
        S_X_RD1,
        S_X_GOT,
        S_O_RD,
        S_O_GOT,
        S_O_WAIT
    } t_state;

endpackage

[design/pmhs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pmhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[design/partial_min_heap_sort.sv]
// Partial min-heap sort top level: load sequencer, heap build, extraction, output.
// Depends on pmhs_pkg and pmhs_ram.
//
// channel  | dir | handshake              | payload
// in       | in  | i_in_valid / o_in_stall | i_in  (pmhs_pkg::t_in)
// out      | out | o_out_valid/ i_out_stall| o_out (pmhs_pkg::t_out)
// cfg      | in  | i_cfg_valid/ o_cfg_ready| i_cfg_data (extract_count)
//
// Loading takes one element per cycle. After the last element the heap is
// built and k extractions run, each sift-down level sharing the single
// read port of the heap RAM. Results then go out one at a time, each held
// until the output stall releases it.
// No input is taken from the last element until the final result is taken.
// Reset is synchronous, active low; RAM contents are not cleared.
module partial_min_heap_sort #(
    parameter int MAX_ITEMS = pmhs_pkg::MAX_ITEMS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  pmhs_pkg::t_in              i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output pmhs_pkg::t_out             o_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [pmhs_pkg::EXT_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int KW = (CW > pmhs_pkg::EXT_W) ? CW : pmhs_pkg::EXT_W;
    localparam int VW = pmhs_pkg::VAL_W;

    pmhs_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_cnt, n_cnt, r_len, n_len, r_i, n_i, r_k, n_k;
    logic [CW-1:0] r_hole, n_hole, r_j, n_j, r_rem, n_rem;
    logic [CW:0]   r_child, n_child;
    logic signed [VW-1:0] r_mov, n_mov, r_c1, n_c1;
    logic          r_two, n_two, r_ext_ph, n_ext_ph;
    logic [pmhs_pkg::EXT_W-1:0] r_ext;
    pmhs_pkg::t_out r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [VW-1:0] wdata, rdata;
    logic signed [VW-1:0] rd_s;

    logic          in_acc, out_acc;
    logic [CW-1:0] w_n, w_k, w_hm1, w_im1;
    logic [CW:0]   w_cm1, w_sel;
    logic signed [VW-1:0] w_cval;
    logic          w_right, w_stop;
    pmhs_pkg::t_state w_ostart, w_after;

    pmhs_ram #(.WIDTH(VW), .DEPTH(MAX_ITEMS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_s        = signed'(rdata);
    assign o_in_stall  = (r_state != pmhs_pkg::S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = r_out_valid && !i_out_stall;

    // loaded count including the element now taken; clamp k to it
    assign w_n = (r_cnt < CW'(MAX_ITEMS)) ? r_cnt + CW'(1) : r_cnt;
    assign w_k = (KW'(r_ext) > KW'(w_n)) ? w_n : CW'(r_ext);

    assign w_hm1   = r_hole - CW'(1);
    assign w_im1   = r_i - CW'(1);
    assign w_cm1   = r_child - (CW+1)'(1);
    assign w_right = r_two && (r_c1 > rd_s);
    assign w_cval  = w_right ? rd_s : r_c1;
    assign w_sel   = w_right ? r_child + (CW+1)'(1) : r_child;
    assign w_stop  = (r_mov <= w_cval);

    assign w_ostart = (r_rem == '0) ? pmhs_pkg::S_O_GOT : pmhs_pkg::S_O_RD;

    // where a finished sift-down continues
    always_comb begin
        if (!r_ext_ph) begin
            if (r_i == CW'(1)) begin
                w_after = (r_k == '0) ? w_ostart : pmhs_pkg::S_X_RD0;
            end else begin
                w_after = pmhs_pkg::S_RD_MOV;
            end
        end else begin
            w_after = (w_im1 == r_rem) ? w_ostart : pmhs_pkg::S_X_RD0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pmhs_pkg::S_LOAD: begin
                if (in_acc && i_in.last_in) begin
                    if ((w_n >> 1) != '0) begin
                        n_state = pmhs_pkg::S_RD_MOV;
                    end else if (w_k != '0) begin
                        n_state = pmhs_pkg::S_X_RD0;
                    end else if (w_n == '0) begin
                        n_state = pmhs_pkg::S_O_GOT;
                    end else begin
                        n_state = pmhs_pkg::S_O_RD;
                    end
                end
            end
            pmhs_pkg::S_RD_MOV:  n_state = pmhs_pkg::S_GOT_MOV;
            pmhs_pkg::S_GOT_MOV: n_state = pmhs_pkg::S_CHK;
            pmhs_pkg::S_CHK: begin
                n_state = (r_child > (CW+1)'(r_len)) ? pmhs_pkg::S_WR : pmhs_pkg::S_C1;
            end
            pmhs_pkg::S_C1:      n_state = pmhs_pkg::S_DEC;
            pmhs_pkg::S_DEC:     n_state = w_stop ? w_after : pmhs_pkg::S_CHK;
            pmhs_pkg::S_WR:      n_state = w_after;
            pmhs_pkg::S_X_RD0:   n_state = pmhs_pkg::S_X_RD1;
            pmhs_pkg::S_X_RD1:   n_state = pmhs_pkg::S_X_GOT;
            pmhs_pkg::S_X_GOT:   n_state = pmhs_pkg::S_CHK;
            pmhs_pkg::S_O_RD:    n_state = pmhs_pkg::S_O_GOT;
            pmhs_pkg::S_O_GOT:   n_state = pmhs_pkg::S_O_WAIT;
            pmhs_pkg::S_O_WAIT: begin
                if (out_acc) begin
                    n_state = r_out.last_out ? pmhs_pkg::S_LOAD : pmhs_pkg::S_O_RD;
                end
            end
            default: n_state = pmhs_pkg::S_LOAD;
        endcase
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_i         = r_i;
        n_k         = r_k;
        n_hole      = r_hole;
        n_child     = r_child;
        n_mov       = r_mov;
        n_c1        = r_c1;
        n_two       = r_two;
        n_ext_ph    = r_ext_ph;
        n_j         = r_j;
        n_rem       = r_rem;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        we          = 1'b0;
        waddr       = r_cnt[AW-1:0];
        wdata       = i_in.value;
        raddr       = w_cm1[AW-1:0];
        unique case (r_state)
            pmhs_pkg::S_LOAD: begin
                if (in_acc) begin
                    we    = (r_cnt < CW'(MAX_ITEMS));
                    n_cnt = w_n;
                    if (i_in.last_in) begin
                        n_len    = w_n;
                        n_k      = w_k;
                        n_rem    = w_n - w_k;
                        n_j      = '0;
                        n_i      = ((w_n >> 1) != '0) ? (w_n >> 1) : w_n;
                        n_ext_ph = ((w_n >> 1) == '0);
                    end
                end
            end
            pmhs_pkg::S_RD_MOV: raddr = w_im1[AW-1:0];
            pmhs_pkg::S_GOT_MOV: begin
                n_mov   = rd_s;
                n_hole  = r_i;
                n_child = {r_i, 1'b0};
            end
            pmhs_pkg::S_CHK: begin
                n_two = (r_child < (CW+1)'(r_len));
            end
            pmhs_pkg::S_C1: begin
                n_c1  = rd_s;
                raddr = r_child[AW-1:0];
            end
            pmhs_pkg::S_DEC: begin
                we    = 1'b1;
                waddr = w_hm1[AW-1:0];
                if (w_stop) begin
                    wdata = r_mov;
                    if (!r_ext_ph && r_i == CW'(1)) begin
                        n_ext_ph = 1'b1;
                        n_i      = r_len;
                    end else begin
                        n_i = w_im1;
                    end
                end else begin
                    wdata   = w_cval;
                    n_hole  = w_sel[CW-1:0];
                    n_child = {w_sel[CW-1:0], 1'b0};
                end
            end
            pmhs_pkg::S_WR: begin
                we    = 1'b1;
                waddr = w_hm1[AW-1:0];
                wdata = r_mov;
                if (!r_ext_ph && r_i == CW'(1)) begin
                    n_ext_ph = 1'b1;
                    n_i      = r_len;
                end else begin
                    n_i = w_im1;
                end
            end
            pmhs_pkg::S_X_RD0: raddr = '0;
            pmhs_pkg::S_X_RD1: begin
                n_c1  = rd_s;
                raddr = w_im1[AW-1:0];
            end
            pmhs_pkg::S_X_GOT: begin
                // old root goes to the heap end; old end sifts down from the root
                we      = 1'b1;
                waddr   = w_im1[AW-1:0];
                wdata   = r_c1;
                n_mov   = rd_s;
                n_hole  = CW'(1);
                n_child = (CW+1)'(2);
                n_len   = w_im1;
            end
            pmhs_pkg::S_O_RD: raddr = r_j[AW-1:0];
            pmhs_pkg::S_O_GOT: begin
                n_out_valid = 1'b1;
                if (r_rem == '0) begin
                    n_out = '{value_out: '0, has_value: 1'b0, last_out: 1'b1};
                end else begin
                    n_out = '{value_out: rd_s, has_value: 1'b1,
                              last_out: (r_j + CW'(1) == r_rem)};
                end
            end
            pmhs_pkg::S_O_WAIT: begin
                if (out_acc) begin
                    n_out_valid = 1'b0;
                    n_j         = r_j + CW'(1);
                    if (r_out.last_out) begin
                        n_cnt = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pmhs_pkg::S_LOAD;
            r_cnt       <= '0;
            r_ext       <= '0;
            r_out_valid <= 1'b0;
            r_ext_ph    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_ext_ph    <= n_ext_ph;
            if (i_cfg_valid && o_cfg_ready) begin
                r_ext <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_i     <= n_i;
        r_k     <= n_k;
        r_hole  <= n_hole;
        r_child <= n_child;
        r_mov   <= n_mov;
        r_c1    <= n_c1;
        r_two   <= n_two;
        r_j     <= n_j;
        r_rem   <= n_rem;
        r_out   <= n_out;
    end

endmodule

[design/pmhs_checker.sv]
// Port-level checker for partial_min_heap_sort, bound to the top level.
// Depends on pmhs_pkg and partial_min_heap_sort_macros.svh.
`include "partial_min_heap_sort_macros.svh"

module pmhs_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input pmhs_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input pmhs_pkg::t_out o_out
);

    `PMHS_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out), "stalled result changed")
    `PMHS_ASSERT(a_no_load_during_out, i_clk, i_rst_n, o_out_valid |-> o_in_stall, "input open while a result is pending")
    `PMHS_ASSERT(a_empty_form, i_clk, i_rst_n, o_out_valid && !o_out.has_value |-> o_out.last_out && o_out.value_out == 0, "malformed empty result")
    `PMHS_ASSERT(a_last_closes, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_in.last_in |=> o_in_stall, "input not closed after last request")
    `PMHS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "not idle after reset")

endmodule

bind partial_min_heap_sort pmhs_checker u_pmhs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
